// ===== design/kerq_pkg.sv =====
// Package for the key event ring queue: sizes, codes, item structs and
// controller/datapath interface structs. No dependencies.
package kerq_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int PTR_W        = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;

  localparam logic [15:0] SCAN_DEL     = 16'h0008;
  localparam logic [31:0] CTRL_BITS    = 32'h0000_000C;
  localparam logic [31:0] ALT_BITS     = 32'h0000_0030;
  localparam logic [7:0]  TOGGLE_VALID = 8'h80;

  // operation codes
  localparam logic [2:0] OP_PUSH      = 3'd0;
  localparam logic [2:0] OP_READ      = 3'd1;
  localparam logic [2:0] OP_READ_EXT  = 3'd2;
  localparam logic [2:0] OP_WAIT_POLL = 3'd3;
  localparam logic [2:0] OP_SET_TOG   = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_DEV_ERR   = 2'd2;
  localparam logic [1:0] ST_UNSUP     = 2'd3;

  // result selection
  localparam logic [2:0] RES_OK        = 3'd0;
  localparam logic [2:0] RES_NOT_READY = 3'd1;
  localparam logic [2:0] RES_DEV_ERR   = 3'd2;
  localparam logic [2:0] RES_UNSUP     = 3'd3;
  localparam logic [2:0] RES_PUSH      = 3'd4;
  localparam logic [2:0] RES_KEY       = 3'd5;
  localparam logic [2:0] RES_AVAIL     = 3'd6;
  localparam logic [2:0] RES_SET       = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] scan_code;
    logic [15:0] unicode_char;
    logic [31:0] shift_state;
    logic [7:0]  toggle_state;
    logic [31:0] modifier_shift;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_scan;
    logic [15:0] out_unicode;
    logic [31:0] out_shift;
    logic [7:0]  out_toggle;
    logic        key_available;
    logic        reset_request;
    logic        indicator_write;
    logic [7:0]  indicator_toggle;
  } out_item_t;

  typedef struct packed {
    logic       latch;
    logic       push;
    logic       clear;
    logic       set_tog;
    logic       adv_head;
    logic       load;
    logic [2:0] res_sel;
  } kerq_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       link_up;
    logic       tog_valid;
    logic       empty;
    logic       empty_next;
    logic       partial;
  } kerq_stat_t;

endpackage

// ===== design/kerq_ctrl.sv =====
// Controller FSM for the key event ring queue.
// Depends on kerq_pkg (codes and command/status structs).
module kerq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_strobe,
  input  kerq_pkg::kerq_stat_t stat,
  output kerq_pkg::kerq_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_EVAL  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       done_r, done_nxt;
  logic       accept;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = done_r;
  assign accept     = start && !busy;

  always_comb begin
    state_nxt   = state_r;
    done_nxt    = 1'b0;
    cmd         = '0;
    cmd.res_sel = kerq_pkg::RES_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        cmd.load  = 1'b1;
        done_nxt  = 1'b1;
        case (stat.op)
          kerq_pkg::OP_PUSH: begin
            cmd.push    = 1'b1;
            cmd.res_sel = kerq_pkg::RES_PUSH;
          end
          kerq_pkg::OP_READ, kerq_pkg::OP_READ_EXT, kerq_pkg::OP_WAIT_POLL: begin
            if (!stat.link_up) begin
              cmd.res_sel = kerq_pkg::RES_DEV_ERR;
            end else if (stat.empty) begin
              cmd.res_sel = (stat.op == kerq_pkg::OP_WAIT_POLL) ?
                            kerq_pkg::RES_OK : kerq_pkg::RES_NOT_READY;
            end else begin
              // head data is already registered; go examine it
              cmd.load  = 1'b0;
              done_nxt  = 1'b0;
              state_nxt = S_EVAL;
            end
          end
          kerq_pkg::OP_SET_TOG: begin
            if (!stat.tog_valid) begin
              cmd.res_sel = kerq_pkg::RES_UNSUP;
            end else if (!stat.link_up) begin
              cmd.res_sel = kerq_pkg::RES_DEV_ERR;
            end else begin
              cmd.set_tog = 1'b1;
              cmd.res_sel = kerq_pkg::RES_SET;
            end
          end
          kerq_pkg::OP_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.res_sel = stat.link_up ? kerq_pkg::RES_OK : kerq_pkg::RES_DEV_ERR;
          end
          default: begin
            cmd.res_sel = kerq_pkg::RES_UNSUP;
          end
        endcase
      end
      S_FETCH: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        cmd.load  = 1'b1;
        done_nxt  = 1'b1;
        if (stat.op == kerq_pkg::OP_WAIT_POLL) begin
          if (!stat.partial) begin
            cmd.res_sel = kerq_pkg::RES_AVAIL;
          end else begin
            cmd.adv_head = 1'b1;
            cmd.res_sel  = kerq_pkg::RES_OK;
            if (!stat.empty_next) begin
              cmd.load  = 1'b0;
              done_nxt  = 1'b0;
              state_nxt = S_FETCH;
            end
          end
        end else begin
          cmd.adv_head = 1'b1;
          if (stat.op == kerq_pkg::OP_READ && stat.partial) begin
            cmd.res_sel = kerq_pkg::RES_NOT_READY;
            if (!stat.empty_next) begin
              cmd.load  = 1'b0;
              done_nxt  = 1'b0;
              state_nxt = S_FETCH;
            end
          end else begin
            cmd.res_sel = kerq_pkg::RES_KEY;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

// ===== design/kerq_dp.sv =====
// Datapath for the key event ring queue: key memories, ring pointers,
// toggle and link registers, result register. Depends on kerq_pkg.
module kerq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kerq_pkg::in_item_t   in_item,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  kerq_pkg::kerq_cmd_t  cmd,
  output kerq_pkg::kerq_stat_t stat,
  output kerq_pkg::out_item_t  out_item
);

  localparam int PW = kerq_pkg::PTR_W;

  // entries: scan<<16 | char, and shift<<8 | toggle
  logic [31:0] code_mem [kerq_pkg::BUFFER_DEPTH];
  logic [39:0] mod_mem  [kerq_pkg::BUFFER_DEPTH];

  kerq_pkg::in_item_t item_r;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0] head_inc, tail_inc;
  logic [7:0]    toggle_reg_r, toggle_reg_nxt;
  logic          link_up_r;
  logic [31:0]   rd_code_r;
  logic [39:0]   rd_mod_r;
  kerq_pkg::out_item_t res_r, res_nxt;
  logic          del_combo;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    if (p == PW'(kerq_pkg::BUFFER_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign head_inc = next_slot(head_r);
  assign tail_inc = next_slot(tail_r);

  assign del_combo = ((item_r.modifier_shift & kerq_pkg::CTRL_BITS) != '0) &&
                     ((item_r.modifier_shift & kerq_pkg::ALT_BITS) != '0) &&
                     (item_r.scan_code == kerq_pkg::SCAN_DEL);

  assign stat.op         = item_r.op;
  assign stat.link_up    = link_up_r;
  assign stat.tog_valid  = item_r.toggle_state[7];
  assign stat.empty      = (head_r == tail_r);
  assign stat.empty_next = (head_inc == tail_r);
  assign stat.partial    = (rd_code_r == '0);

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    toggle_reg_nxt = toggle_reg_r;
    if (cmd.push) begin
      // full ring: drop the oldest key
      if (tail_inc == head_r) begin
        head_nxt = head_inc;
      end
      tail_nxt = tail_inc;
    end else if (cmd.clear) begin
      head_nxt       = '0;
      tail_nxt       = '0;
      toggle_reg_nxt = kerq_pkg::TOGGLE_VALID;
    end else if (cmd.adv_head) begin
      head_nxt = head_inc;
    end
    if (cmd.set_tog) begin
      toggle_reg_nxt = item_r.toggle_state;
    end
  end

  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      kerq_pkg::RES_OK:        res_nxt.status = kerq_pkg::ST_OK;
      kerq_pkg::RES_NOT_READY: res_nxt.status = kerq_pkg::ST_NOT_READY;
      kerq_pkg::RES_DEV_ERR:   res_nxt.status = kerq_pkg::ST_DEV_ERR;
      kerq_pkg::RES_UNSUP:     res_nxt.status = kerq_pkg::ST_UNSUP;
      kerq_pkg::RES_PUSH:      res_nxt.reset_request = del_combo;
      kerq_pkg::RES_KEY: begin
        res_nxt.out_scan    = rd_code_r[31:16];
        res_nxt.out_unicode = rd_code_r[15:0];
        if (item_r.op == kerq_pkg::OP_READ_EXT) begin
          res_nxt.out_shift  = rd_mod_r[39:8];
          res_nxt.out_toggle = rd_mod_r[7:0];
        end
      end
      kerq_pkg::RES_AVAIL:     res_nxt.key_available = 1'b1;
      kerq_pkg::RES_SET:       res_nxt.indicator_write = 1'b1;
      default:                 res_nxt.status = kerq_pkg::ST_UNSUP;
    endcase
  end

  // indicator value comes from the toggle register written with the result
  always_comb begin
    out_item                  = res_r;
    out_item.indicator_toggle = res_r.indicator_write ? toggle_reg_r : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      code_mem[tail_r] <= {item_r.scan_code, item_r.unicode_char};
      mod_mem[tail_r]  <= {item_r.shift_state, item_r.toggle_state};
    end
    rd_code_r <= code_mem[head_r];
    rd_mod_r  <= mod_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
    if (cmd.load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      toggle_reg_r <= kerq_pkg::TOGGLE_VALID;
      link_up_r    <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      toggle_reg_r <= toggle_reg_nxt;
      if (cfg_we) begin
        link_up_r <= cfg_wdata;
      end
    end
  end

endmodule

// ===== design/key_event_ring_queue_unit.sv =====
// Push, set, clear, unused ops, link-down errors and reads or polls of an empty ring go
// from accept through the execute state to the result; reads and polls of a non-empty ring
// add the evaluate state, and each partial key dropped with keys behind it adds fetch and evaluate.
// The next item is taken at the edge ending the result strobe, so no new item is taken before
// the last one is through; the head read/examine loop sets the pace.
// Reset (rst_n low, synchronous): ring empty, toggle 0x80, link down. No result stall.
module key_event_ring_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kerq_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output kerq_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  kerq_pkg::kerq_cmd_t  cmd;
  kerq_pkg::kerq_stat_t stat;

  kerq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .stat       (stat),
    .cmd        (cmd)
  );

  kerq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule

// ===== design/kerq_checker.sv =====
// Port-level checks for key_event_ring_queue_unit, bound to the top level.
// Depends on kerq_pkg.
module kerq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input kerq_pkg::out_item_t out_item
);

  // result strobes never come on consecutive cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on consecutive cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a transaction");

  a_strobe_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("busy while strobing a result");

  a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != kerq_pkg::ST_OK) |->
      (!out_item.key_available && !out_item.reset_request && !out_item.indicator_write))
    else $error("flag set on a failed transaction");

  a_ind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.indicator_write) |-> out_item.indicator_toggle[7])
    else $error("indicator write without valid bit");

endmodule

bind key_event_ring_queue_unit kerq_checker u_kerq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for key_event_ring_queue_unit. A command queue feeds a
// clocked driver, a monitor checks each reply against an in-bench ring model.
// Depends on kerq_pkg and the block's RTL.
module tb;

  localparam int CYCLE_LIMIT = 500000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  kerq_pkg::in_item_t  cmd_item = '0;
  logic                out_strobe;
  kerq_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;

  key_event_ring_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (cmd_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring model state
  logic [31:0] key_mem [kerq_pkg::BUFFER_DEPTH];
  logic [39:0] mod_mem [kerq_pkg::BUFFER_DEPTH];
  int          ring_head = 0;
  int          ring_tail = 0;
  logic [7:0]  toggle_state_m = kerq_pkg::TOGGLE_VALID;
  logic        link_m = 1'b0;

  kerq_pkg::in_item_t  queued_cmds[$];
  kerq_pkg::out_item_t expected_replies[$];
  kerq_pkg::out_item_t want_reply;
  int        gap_pct = 24;
  int        mismatches = 0;
  int        n_cmds = 0;
  int        n_replies = 0;
  int        n_cad = 0;
  int        n_overwrites = 0;
  int        n_partial_skips = 0;
  int        cycles = 0;

  function automatic int next_slot(int p);
    return (p == kerq_pkg::BUFFER_DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic void predict_reply(kerq_pkg::in_item_t c);
    kerq_pkg::out_item_t r;
    int        slot;
    bit        done;
    r = '0;
    case (c.op)
      kerq_pkg::OP_PUSH: begin
        if ((c.modifier_shift & kerq_pkg::CTRL_BITS) != '0 &&
            (c.modifier_shift & kerq_pkg::ALT_BITS) != '0 &&
            c.scan_code == kerq_pkg::SCAN_DEL) begin
          r.reset_request = 1'b1;
          n_cad++;
        end
        // full ring: oldest key is dropped
        if (next_slot(ring_tail) == ring_head) begin
          ring_head = next_slot(ring_head);
          n_overwrites++;
        end
        key_mem[ring_tail] = {c.scan_code, c.unicode_char};
        mod_mem[ring_tail] = {c.shift_state, c.toggle_state};
        ring_tail = next_slot(ring_tail);
      end
      kerq_pkg::OP_READ, kerq_pkg::OP_READ_EXT: begin
        if (!link_m) begin
          r.status = kerq_pkg::ST_DEV_ERR;
        end else begin
          r.status = kerq_pkg::ST_NOT_READY;
          done = 1'b0;
          while (!done && ring_head != ring_tail) begin
            slot = ring_head;
            ring_head = next_slot(ring_head);
            if (c.op == kerq_pkg::OP_READ_EXT || key_mem[slot] != 32'h0) begin
              done = 1'b1;
              r.status = kerq_pkg::ST_OK;
              r.out_scan = key_mem[slot][31:16];
              r.out_unicode = key_mem[slot][15:0];
              if (c.op == kerq_pkg::OP_READ_EXT) begin
                r.out_shift = mod_mem[slot][39:8];
                r.out_toggle = mod_mem[slot][7:0];
              end
            end else begin
              n_partial_skips++;
            end
          end
        end
      end
      kerq_pkg::OP_WAIT_POLL: begin
        if (!link_m) begin
          r.status = kerq_pkg::ST_DEV_ERR;
        end else begin
          while (ring_head != ring_tail && key_mem[ring_head] == 32'h0) begin
            ring_head = next_slot(ring_head);
            n_partial_skips++;
          end
          r.key_available = (ring_head != ring_tail);
        end
      end
      kerq_pkg::OP_SET_TOG: begin
        if ((c.toggle_state & kerq_pkg::TOGGLE_VALID) == 8'h0) begin
          r.status = kerq_pkg::ST_UNSUP;
        end else if (!link_m) begin
          r.status = kerq_pkg::ST_DEV_ERR;
        end else begin
          toggle_state_m = c.toggle_state;
          r.indicator_write = 1'b1;
          r.indicator_toggle = toggle_state_m;
        end
      end
      kerq_pkg::OP_CLEAR: begin
        r.status = link_m ? kerq_pkg::ST_OK : kerq_pkg::ST_DEV_ERR;
        ring_head = 0;
        ring_tail = 0;
        toggle_state_m = kerq_pkg::TOGGLE_VALID;
      end
      default: r.status = kerq_pkg::ST_UNSUP;
    endcase
    expected_replies.push_back(r);
  endfunction

  function automatic kerq_pkg::in_item_t key_op(logic [2:0] op, logic [15:0] scan,
                                                logic [15:0] uch, logic [31:0] shf,
                                                logic [7:0] tog, logic [31:0] modf);
    kerq_pkg::in_item_t c;
    c.op = op;
    c.scan_code = scan;
    c.unicode_char = uch;
    c.shift_state = shf;
    c.toggle_state = tog;
    c.modifier_shift = modf;
    return c;
  endfunction

  function automatic kerq_pkg::in_item_t random_key_op(int push_pct);
    kerq_pkg::in_item_t c;
    int       sel;
    c = key_op(kerq_pkg::OP_PUSH, 16'($urandom), 16'($urandom), $urandom, 8'($urandom),
               $urandom);
    sel = $urandom_range(0, 99);
    if (sel >= push_pct) begin
      sel = $urandom_range(0, 99);
      if (sel < 35)      c.op = kerq_pkg::OP_READ;
      else if (sel < 60) c.op = kerq_pkg::OP_READ_EXT;
      else if (sel < 78) c.op = kerq_pkg::OP_WAIT_POLL;
      else if (sel < 90) c.op = kerq_pkg::OP_SET_TOG;
      else if (sel < 95) c.op = kerq_pkg::OP_CLEAR;
      else               c.op = 3'($urandom_range(6, 7));
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        c.scan_code = '0;
        c.unicode_char = '0;
      end
      2: begin
        c.scan_code = kerq_pkg::SCAN_DEL;
        if ($urandom_range(0, 1) == 0)
          c.modifier_shift = $urandom & (kerq_pkg::CTRL_BITS | kerq_pkg::ALT_BITS);
      end
      default: ;
    endcase
    return c;
  endfunction

  // driver: one transaction per accept, next one presented in the same step
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_reply(cmd_item);
        n_cmds++;
      end
      if (start && busy) begin
        // hold the pending transaction
      end else if (queued_cmds.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        cmd_item <= queued_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) begin
      if (expected_replies.size() == 0) begin
        $error("reply strobed with no transaction outstanding");
        mismatches++;
      end else begin
        want_reply = expected_replies.pop_front();
        check_field("status", 32'(want_reply.status), 32'(out_item.status));
        check_field("out_scan", 32'(want_reply.out_scan), 32'(out_item.out_scan));
        check_field("out_unicode", 32'(want_reply.out_unicode), 32'(out_item.out_unicode));
        check_field("out_shift", want_reply.out_shift, out_item.out_shift);
        check_field("out_toggle", 32'(want_reply.out_toggle), 32'(out_item.out_toggle));
        check_field("key_available", 32'(want_reply.key_available),
                    32'(out_item.key_available));
        check_field("reset_request", 32'(want_reply.reset_request),
                    32'(out_item.reset_request));
        check_field("indicator_write", 32'(want_reply.indicator_write),
                    32'(out_item.indicator_write));
        check_field("indicator_toggle", 32'(want_reply.indicator_toggle),
                    32'(out_item.indicator_toggle));
        n_replies++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles,
               expected_replies.size());
      $display("FAILURE");
      $finish;
    end
  end

  // only called with the block idle
  task automatic write_link(logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    link_m = v;
  endtask

  task automatic drain_ring();
    do @(negedge clk);
    while (queued_cmds.size() != 0 || start || expected_replies.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  int ph_link [5] = '{1, 1, 0, 1, 1};
  int ph_push [5] = '{45, 45, 50, 75, 30};
  int ph_gap  [5] = '{24, 0, 24, 24, 24};
  int ph_count[5] = '{300, 200, 150, 300, 300};

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // link down: every op, set-toggle with and without the valid bit
    write_link(1'b0);
    @(negedge clk);
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, 16'h1234, 16'h0041, 32'h1, 8'h0, 32'h0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_READ, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_READ_EXT, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_WAIT_POLL, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_SET_TOG, '0, '0, '0, 8'h80, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_SET_TOG, '0, '0, '0, 8'h00, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(3'd6, '1, '1, '1, '1, '1));
    queued_cmds.push_back(key_op(3'd7, '0, '0, '0, '0, '0));
    drain_ring();

    // link up: partial keys, ctrl-alt-del, field extremes, empty reads
    write_link(1'b1);
    @(negedge clk);
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, '0, '0, 32'h5, 8'h3, 32'h0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_WAIT_POLL, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, '0, '0, '1, '1, '1));
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_READ, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, kerq_pkg::SCAN_DEL, '0, '0, '0,
                                 kerq_pkg::CTRL_BITS | kerq_pkg::ALT_BITS));
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, kerq_pkg::SCAN_DEL, 16'h7f, '0, '0,
                                 32'h0000_0024));
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, kerq_pkg::SCAN_DEL, '0, '0, '0,
                                 32'hFFFF_FFC3));
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, '1, '1, '1, '1, '1));
    queued_cmds.push_back(key_op(kerq_pkg::OP_PUSH, '0, 16'h0061, 32'h8000_0000, 8'h80, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_WAIT_POLL, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_READ_EXT, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_READ_EXT, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_READ, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_READ_EXT, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_READ, '0, '0, '0, '0, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_SET_TOG, '0, '0, '0, 8'h7F, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_SET_TOG, '0, '0, '0, 8'hFF, '0));
    queued_cmds.push_back(key_op(kerq_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
    drain_ring();

    for (int p = 0; p < 5; p++) begin
      write_link(ph_link[p][0]);
      @(negedge clk);
      gap_pct = ph_gap[p];
      for (int i = 0; i < ph_count[p]; i++)
        queued_cmds.push_back(random_key_op(ph_push[p]));
      drain_ring();
    end

    $display("%0d transactions, %0d replies checked; %0d ctrl-alt-del pushes,",
             n_cmds, n_replies, n_cad);
    $display("%0d ring overwrites, %0d partial keys dropped by reads and polls",
             n_overwrites, n_partial_skips);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/kerq_pkg.sv
design/kerq_ctrl.sv
design/kerq_dp.sv
design/key_event_ring_queue_unit.sv
design/kerq_checker.sv
tb/tb.sv
